// File: hw/rtl/sosp_pkg.sv
// shared constants, payload types and codes for the set of stacks with pop-at
package sosp_pkg;

   localparam int SUB_DEPTH  = 16;
   localparam int NUM_STACKS = 16;

   localparam int DATA_W   = 32;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int SIDX_W   = 4;
   localparam int CNT_W    = $clog2(SUB_DEPTH + 1);
   localparam int IDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int NUM_W    = IDX_W + 1;
   localparam int ADDR_W   = (NUM_STACKS * SUB_DEPTH > 1) ?
                             $clog2(NUM_STACKS * SUB_DEPTH) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SUB_CAPACITY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS_IN_USE = 1'd1;

   localparam logic [CSR_W-1:0] SUB_CAPACITY_RESET  = 5'd10;
   localparam logic [CSR_W-1:0] STACKS_IN_USE_RESET = 5'd10;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_POP_AT = 2'd2,
      ACT_PEEK   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FIND = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_STAT = 4'b1000
   } state_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] push_value;
      logic [SIDX_W-1:0]        stack_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic                     is_empty;
      logic                     is_full;
      logic                     error;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
   } cnt_wr_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } find_type;

endpackage

// File: hw/rtl/set_of_stacks_pop_at.sv
// set of stacks with pop-at: sequencer, configuration and output register
//
// A stack built from a row of fixed-size sub-stacks. Requests arrive on the
// req_ channel (valid/ready) as push, pop, pop at a named sub-stack or peek;
// each one gives exactly one result on the rsp_ channel (valid/ready) with the
// peeked value, the empty and full status after the step and an error flag.
// A refused request leaves the state unchanged and returns a zero value.
// csr_ writes set the sub-stack capacity (index 0) and the number of
// sub-stacks in use (index 1); write only while no request is in flight.
// Each request passes through a search, then a count update or element
// access on the single count read port and element ram, then a status read
// with the result load. req_ready is high only while the sequencer is idle,
// so one request is in flight at a time and a new request is taken only
// after the result of the last one has been loaded into the output register.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and holds in its status step until the register
// frees. Synchronous reset empties all sub-stacks, points at sub-stack zero,
// restores both registers to ten and leaves no result pending.
module set_of_stacks_pop_at (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sosp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sosp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [sosp_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [sosp_pkg::CSR_W-1:0]        csr_wdata
);

   sosp_pkg::state_type state_ff, state_in;
   sosp_pkg::req_type   req_ff, req_in;
   sosp_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [sosp_pkg::IDX_W-1:0] cur_ff, cur_in;
   logic [sosp_pkg::IDX_W-1:0] tgt_ff, tgt_in;
   logic                err_ff, err_in;
   logic [sosp_pkg::CSR_W-1:0] sub_cap_ff, stacks_use_ff;

   logic [sosp_pkg::CNT_W-1:0]  cap_eff;
   logic [sosp_pkg::NUM_W-1:0]  num_eff;
   logic [sosp_pkg::IDX_W-1:0]  rd_idx;
   logic [sosp_pkg::CNT_W-1:0]  rd_cnt;
   logic [sosp_pkg::IDX_W-1:0]  find_start;
   sosp_pkg::find_type          find;
   logic                        first_empty;
   sosp_pkg::cnt_wr_type        cnt_wr;
   logic                        mem_we, mem_re;
   logic [sosp_pkg::ADDR_W-1:0] mem_addr;
   logic [sosp_pkg::CNT_W-1:0]  slot;
   logic [sosp_pkg::DATA_W-1:0] mem_rdata;
   logic [sosp_pkg::NUM_W-1:0]  next_c;
   logic                        cnt_full;

   // register values clamped into range
   always_comb begin
      if (sub_cap_ff == '0) begin
         cap_eff = sosp_pkg::CNT_W'(1);
      end else if (int'(sub_cap_ff) > sosp_pkg::SUB_DEPTH) begin
         cap_eff = sosp_pkg::CNT_W'(sosp_pkg::SUB_DEPTH);
      end else begin
         cap_eff = sosp_pkg::CNT_W'(sub_cap_ff);
      end
      if (stacks_use_ff == '0) begin
         num_eff = sosp_pkg::NUM_W'(1);
      end else if (int'(stacks_use_ff) > sosp_pkg::NUM_STACKS) begin
         num_eff = sosp_pkg::NUM_W'(sosp_pkg::NUM_STACKS);
      end else begin
         num_eff = sosp_pkg::NUM_W'(stacks_use_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_cap_ff    <= sosp_pkg::SUB_CAPACITY_RESET;
         stacks_use_ff <= sosp_pkg::STACKS_IN_USE_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            sosp_pkg::CSR_SUB_CAPACITY: begin
               sub_cap_ff <= csr_wdata;
            end
            sosp_pkg::CSR_STACKS_IN_USE: begin
               stacks_use_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_idx     = (state_ff == sosp_pkg::ST_EXEC) ? tgt_ff : cur_ff;
   assign find_start = (req_ff.action == sosp_pkg::ACT_POP_AT) ?
                       sosp_pkg::IDX_W'(req_ff.stack_index) : cur_ff;
   assign cnt_full   = (rd_cnt >= cap_eff);
   assign slot       = (req_ff.action == sosp_pkg::ACT_PUSH) ? rd_cnt :
                       sosp_pkg::CNT_W'(rd_cnt - 1'b1);
   assign mem_addr   = sosp_pkg::ADDR_W'(int'(tgt_ff) * sosp_pkg::SUB_DEPTH + int'(slot));

   sosp_cnt u_cnt (
      .clock       (clock),
      .reset       (reset),
      .rd_idx      (rd_idx),
      .rd_cnt      (rd_cnt),
      .find_start  (find_start),
      .find        (find),
      .first_empty (first_empty),
      .wr          (cnt_wr)
   );

   sosp_ram #(
      .WIDTH (sosp_pkg::DATA_W),
      .DEPTH (sosp_pkg::NUM_STACKS * sosp_pkg::SUB_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (req_ff.push_value),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      err_in       = err_ff;
      cnt_wr       = '0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      next_c       = '0;
      case (state_ff)
         sosp_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = sosp_pkg::ST_FIND;
            end
         end
         sosp_pkg::ST_FIND: begin
            err_in   = 1'b0;
            tgt_in   = find.idx;
            state_in = sosp_pkg::ST_EXEC;
            case (req_ff.action)
               sosp_pkg::ACT_PUSH: begin
                  next_c = {1'b0, cur_ff} + sosp_pkg::NUM_W'(cnt_full);
                  tgt_in = sosp_pkg::IDX_W'(next_c);
                  err_in = ({1'b0, cur_ff} >= num_eff) || (next_c >= num_eff);
               end
               sosp_pkg::ACT_POP, sosp_pkg::ACT_PEEK: begin
                  err_in = !find.found;
               end
               sosp_pkg::ACT_POP_AT: begin
                  err_in = (int'(req_ff.stack_index) >= int'(num_eff)) || !find.found;
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
         sosp_pkg::ST_EXEC: begin
            state_in = sosp_pkg::ST_STAT;
            if (!err_ff) begin
               case (req_ff.action)
                  sosp_pkg::ACT_PUSH: begin
                     if (cnt_full) begin
                        err_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        cnt_wr = '{en: 1'b1, idx: tgt_ff,
                                   cnt: sosp_pkg::CNT_W'(rd_cnt + 1'b1)};
                        cur_in = tgt_ff;
                     end
                  end
                  sosp_pkg::ACT_POP: begin
                     cnt_wr = '{en: 1'b1, idx: tgt_ff,
                                cnt: sosp_pkg::CNT_W'(rd_cnt - 1'b1)};
                     cur_in = tgt_ff;
                  end
                  sosp_pkg::ACT_POP_AT: begin
                     cnt_wr = '{en: 1'b1, idx: tgt_ff,
                                cnt: sosp_pkg::CNT_W'(rd_cnt - 1'b1)};
                  end
                  sosp_pkg::ACT_PEEK: begin
                     mem_re = 1'b1;
                     cur_in = tgt_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sosp_pkg::ST_STAT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.top_value = (req_ff.action == sosp_pkg::ACT_PEEK && !err_ff) ?
                                  mem_rdata : '0;
               rsp_in.is_empty  = (cur_ff == '0) && first_empty;
               rsp_in.is_full   = (({1'b0, cur_ff} + 1'b1) == num_eff) && cnt_full;
               rsp_in.error     = err_ff;
               state_in         = sosp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sosp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sosp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      tgt_ff <= tgt_in;
      err_ff <= err_in;
   end

   assign req_ready = (state_ff == sosp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/sosp_ram.sv
// generic single write port ram with registered read
module sosp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sosp_cnt.sv
// sub-stack element counts with one read port and a non-empty search
module sosp_cnt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sosp_pkg::IDX_W-1:0]     rd_idx,
   output logic [sosp_pkg::CNT_W-1:0]     rd_cnt,
   input  logic [sosp_pkg::IDX_W-1:0]     find_start,
   output sosp_pkg::find_type             find,
   output logic                           first_empty,
   input  sosp_pkg::cnt_wr_type           wr
);

   logic [sosp_pkg::CNT_W-1:0] cnt_ff [sosp_pkg::NUM_STACKS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sosp_pkg::NUM_STACKS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (wr.en) begin
         cnt_ff[wr.idx] <= wr.cnt;
      end
   end

   assign rd_cnt      = cnt_ff[rd_idx];
   assign first_empty = (cnt_ff[0] == '0);

   // highest non-empty sub-stack at or below the start
   always_comb begin
      find.found = 1'b0;
      find.idx   = '0;
      for (int i = 0; i < sosp_pkg::NUM_STACKS; i++) begin
         if ((cnt_ff[i] != '0) && (i <= int'(find_start))) begin
            find.found = 1'b1;
            find.idx   = sosp_pkg::IDX_W'(i);
         end
      end
   end

endmodule

// File: hw/rtl/sosp_chk.sv
// port-level checks for the set of stacks with pop-at
module sosp_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input sosp_pkg::rsp_type              rsp_data
);

   // one request in flight at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.top_value == '0)
      else $error("refused request returned a value");

   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("empty and full together");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind set_of_stacks_pop_at sosp_chk u_sosp_chk (.*);
